>>> design/lidar_sector_min_range_macros.svh
// assertion macros used by the property file
`ifndef LIDAR_SECTOR_MIN_RANGE_MACROS_SVH
`define LIDAR_SECTOR_MIN_RANGE_MACROS_SVH

// same-cycle implication, checked while reset is released
`define LSMR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lsmr property failed");

// next-cycle implication, checked while reset is released
`define LSMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lsmr property failed");

`endif

>>> design/lsmr_pkg.sv
package lsmr_pkg;

    // field and register widths
    localparam int unsigned RANGE_W   = 16;
    localparam int unsigned CTR_W     = 12;
    localparam int unsigned HW_W      = 11;
    localparam int unsigned LEN_W     = 13;
    localparam int unsigned IDX_W     = 13;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 16;
    localparam int unsigned NUM_SEC   = 3;

    // longest scan the length register can express
    localparam int unsigned LEN_MAX              = 8191;
    localparam int unsigned LSMR_MAX_SCAN_POINTS = 4096;

    // sector lanes
    localparam int unsigned SEC_FRONT = 0;
    localparam int unsigned SEC_LEFT  = 1;
    localparam int unsigned SEC_RIGHT = 2;

    // register reset values
    localparam logic [CTR_W-1:0]   RST_FRONT_CENTER = 12'd0;
    localparam logic [CTR_W-1:0]   RST_LEFT_CENTER  = 12'd90;
    localparam logic [CTR_W-1:0]   RST_RIGHT_CENTER = 12'd270;
    localparam logic [HW_W-1:0]    RST_HALF_WINDOW  = 11'd5;
    localparam logic [LEN_W-1:0]   RST_SCAN_LENGTH  = 13'd360;
    localparam logic [RANGE_W-1:0] RST_RANGE_FLOOR  = 16'd120;
    localparam logic [RANGE_W-1:0] RST_RANGE_CEIL   = 16'd3500;

    // marks a sector minimum with no usable sample yet
    localparam logic [RANGE_W-1:0] BEST_NONE = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRONT_CENTER = 3'd0,
        CFG_LEFT_CENTER  = 3'd1,
        CFG_RIGHT_CENTER = 3'd2,
        CFG_HALF_WINDOW  = 3'd3,
        CFG_SCAN_LENGTH  = 3'd4,
        CFG_RANGE_FLOOR  = 3'd5,
        CFG_RANGE_CEIL   = 3'd6
    } t_cfg_idx;

    // effective window settings seen by the accumulator
    typedef struct packed {
        logic [LEN_W-1:0]   scan_len;
        logic [HW_W-1:0]    half_win;
        logic [RANGE_W-1:0] floor_mm;
        logic [RANGE_W-1:0] ceil_mm;
    } t_win_cfg;

    // one center index per sector, front in the low bits
    typedef logic [NUM_SEC-1:0][CTR_W-1:0] t_ctr_arr;

    // one sample held in the input register
    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               ok;
        logic               last;
    } t_sample;

    // three sector distances, front in the low bits
    typedef logic [NUM_SEC-1:0][RANGE_W-1:0] t_dist_arr;

endpackage

>>> design/lsmr_cfg_regs.sv
module lsmr_cfg_regs #(
    parameter int unsigned MAX_SCAN_POINTS = lsmr_pkg::LSMR_MAX_SCAN_POINTS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lsmr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lsmr_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    output lsmr_pkg::t_win_cfg                 o_cfg,
    output lsmr_pkg::t_ctr_arr                 o_centers,
    output logic                               o_restart
);
    import lsmr_pkg::*;

    localparam int unsigned LEN_LIMIT =
        (MAX_SCAN_POINTS < LEN_MAX) ? MAX_SCAN_POINTS : LEN_MAX;
    localparam logic [LEN_W-1:0] LEN_LIMIT_V = LEN_W'(LEN_LIMIT);

    logic [CTR_W-1:0]   r_front_center;
    logic [CTR_W-1:0]   r_left_center;
    logic [CTR_W-1:0]   r_right_center;
    logic [HW_W-1:0]    r_half_window;
    logic [LEN_W-1:0]   r_scan_length;
    logic [RANGE_W-1:0] r_range_floor;
    logic [RANGE_W-1:0] r_range_ceil;
    t_cfg_idx           wr_idx;

    assign o_cfg_ready = 1'b1;
    assign wr_idx      = t_cfg_idx'(i_cfg_index);

    // register file, one write per transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_center <= RST_FRONT_CENTER;
            r_left_center  <= RST_LEFT_CENTER;
            r_right_center <= RST_RIGHT_CENTER;
            r_half_window  <= RST_HALF_WINDOW;
            r_scan_length  <= RST_SCAN_LENGTH;
            r_range_floor  <= RST_RANGE_FLOOR;
            r_range_ceil   <= RST_RANGE_CEIL;
        end else if (i_cfg_valid) begin
            case (wr_idx)
                CFG_FRONT_CENTER: r_front_center <= i_cfg_data[CTR_W-1:0];
                CFG_LEFT_CENTER:  r_left_center  <= i_cfg_data[CTR_W-1:0];
                CFG_RIGHT_CENTER: r_right_center <= i_cfg_data[CTR_W-1:0];
                CFG_HALF_WINDOW:  r_half_window  <= i_cfg_data[HW_W-1:0];
                CFG_SCAN_LENGTH:  r_scan_length  <= i_cfg_data[LEN_W-1:0];
                CFG_RANGE_FLOOR:  r_range_floor  <= i_cfg_data;
                CFG_RANGE_CEIL:   r_range_ceil   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // centers or length changed: reduced centers must be recomputed
    assign o_restart = i_cfg_valid &&
        (wr_idx inside {CFG_FRONT_CENTER, CFG_LEFT_CENTER, CFG_RIGHT_CENTER,
                        CFG_SCAN_LENGTH});

    // effective length and half width
    always_comb begin
        if (r_scan_length == '0) begin
            o_cfg.scan_len = LEN_W'(1);
        end else if (r_scan_length > LEN_LIMIT_V) begin
            o_cfg.scan_len = LEN_LIMIT_V;
        end else begin
            o_cfg.scan_len = r_scan_length;
        end
        o_cfg.half_win = (r_half_window == '0) ? HW_W'(1) : r_half_window;
        o_cfg.floor_mm = r_range_floor;
        o_cfg.ceil_mm  = r_range_ceil;
    end

    assign o_centers[SEC_FRONT] = r_front_center;
    assign o_centers[SEC_LEFT]  = r_left_center;
    assign o_centers[SEC_RIGHT] = r_right_center;

endmodule

>>> design/lsmr_mod_unit.sv
module lsmr_mod_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_restart,
    input  logic [lsmr_pkg::LEN_W-1:0]     i_len,
    input  lsmr_pkg::t_ctr_arr             i_centers,
    output lsmr_pkg::t_ctr_arr             o_rem,
    output logic                           o_busy
);
    import lsmr_pkg::*;

    // one quotient bit per cycle, all three centers side by side
    localparam int unsigned STEPS = CTR_W;
    localparam int unsigned CNT_W = $clog2(STEPS);

    logic                             r_pend;
    logic                             r_run;
    logic [CNT_W-1:0]                 r_cnt;
    t_ctr_arr                         r_div;
    logic [NUM_SEC-1:0][LEN_W-1:0]    r_rem;
    logic [NUM_SEC-1:0][LEN_W-1:0]    n_rem;

    // sequencing: load in the cycle after a restart, then run the steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b1;
            r_run  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_pend <= i_restart;
            if (r_pend) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(STEPS - 1);
            end else if (r_run) begin
                if (r_cnt == '0) begin
                    r_run <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // restoring remainder step per lane
    for (genvar k = 0; k < NUM_SEC; k++) begin : g_lane
        logic [LEN_W:0] trial;
        always_comb begin
            trial = {r_rem[k], r_div[k][CTR_W-1]};
            if (trial >= {1'b0, i_len}) begin
                trial = trial - {1'b0, i_len};
            end
            n_rem[k] = trial[LEN_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (r_pend) begin
                r_div[k] <= i_centers[k];
                r_rem[k] <= '0;
            end else if (r_run) begin
                r_div[k] <= {r_div[k][CTR_W-2:0], 1'b0};
                r_rem[k] <= n_rem[k];
            end
        end

        // remainder never exceeds the center itself
        assign o_rem[k] = r_rem[k][CTR_W-1:0];
    end

    assign o_busy = r_pend || r_run;

endmodule

>>> design/lsmr_sector_acc.sv
module lsmr_sector_acc (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lsmr_pkg::t_win_cfg                     i_cfg,
    input  lsmr_pkg::t_ctr_arr                     i_centers,
    input  logic                                   i_busy,
    input  logic                                   i_valid,
    input  lsmr_pkg::t_sample                      i_sample,
    output logic                                   o_take,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output lsmr_pkg::t_dist_arr                    o_m_axis_tdata
);
    import lsmr_pkg::*;

    // index idx lies within half_win of center c, modulo n (c below n)
    function automatic logic in_window(
        input logic [IDX_W-1:0] idx,
        input logic [CTR_W-1:0] c,
        input logic [LEN_W-1:0] n,
        input logic [HW_W-1:0]  hw
    );
        logic [IDX_W:0] d;
        if (idx >= {1'b0, c}) begin
            d = {1'b0, idx - {1'b0, c}};
        end else begin
            d = {1'b0, idx} + {1'b0, n} - {2'b0, c};
        end
        return (d <= {3'b0, hw}) || ({2'b0, hw} >= n) ||
               (d >= ({1'b0, n} - {3'b0, hw}));
    endfunction

    logic [IDX_W-1:0]                r_idx;
    t_dist_arr                       r_best;
    t_dist_arr                       n_best;
    t_dist_arr                       n_report;
    logic                            r_out_valid;
    t_dist_arr                       r_out_data;
    logic                            usable;

    // consume the held sample unless the remainder pass is busy or its result has nowhere to go
    assign o_take = i_valid && !i_busy &&
                    (!i_sample.last || !r_out_valid || i_m_axis_tready);

    // sample qualifies for any sector
    assign usable = ({1'b0, r_idx} < {1'b0, i_cfg.scan_len}) && i_sample.ok &&
                    (i_sample.range_mm >= i_cfg.floor_mm) &&
                    (i_sample.range_mm <= i_cfg.ceil_mm);

    // per sector running minimum and reported value
    for (genvar k = 0; k < NUM_SEC; k++) begin : g_sec
        logic hit;
        assign hit = usable && (i_sample.range_mm < r_best[k]) &&
                     in_window(r_idx, i_centers[k], i_cfg.scan_len, i_cfg.half_win);
        assign n_best[k]   = hit ? i_sample.range_mm : r_best[k];
        assign n_report[k] = (n_best[k] == BEST_NONE) ? i_cfg.ceil_mm : n_best[k];
    end

    // scan state: index and minimums, cleared after the last sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_best <= {NUM_SEC{BEST_NONE}};
        end else if (o_take) begin
            if (i_sample.last) begin
                r_idx  <= '0;
                r_best <= {NUM_SEC{BEST_NONE}};
            end else begin
                r_best <= n_best;
                if (r_idx != '1) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take && i_sample.last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_sample.last) begin
            r_out_data <= n_report;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

>>> design/lidar_sector_min_range.sv
// channel     | direction | transfer                     | payload
// ------------+-----------+------------------------------+----------------------------------
// s_axis      | in        | tvalid & tready              | tdata range_sample, tuser
//             |           |                              | sample_valid, tlast scan_end
// m_axis      | out       | tvalid & tready              | tdata dist_front/left/right
// cfg         | in        | valid & ready (ready high)   | index, data
//
// One sample per cycle outside the stalls below; a result leaves after the
// transfer of its scan_end sample via the input register, then the result register.
// After reset and after any write of a center index or the scan length, the
// input is held off while the three centers are reduced modulo the scan
// length, one remainder bit per cycle.
// Samples keep flowing while a result waits; only a scan_end sample stalls
// in the input register until the result register is free.
module lidar_sector_min_range #(
    parameter int unsigned MAX_SCAN_POINTS = lsmr_pkg::LSMR_MAX_SCAN_POINTS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    input  logic [lsmr_pkg::RANGE_W-1:0]                 i_s_axis_tdata,  // [15:0] range_sample
    input  logic                                         i_s_axis_tuser,  // [0] sample_valid
    input  logic                                         i_s_axis_tlast,
    output logic                                         o_m_axis_tvalid,
    input  logic                                         i_m_axis_tready,
    // [15:0] dist_front, [31:16] dist_left, [47:32] dist_right
    output logic [lsmr_pkg::NUM_SEC*lsmr_pkg::RANGE_W-1:0] o_m_axis_tdata,
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [lsmr_pkg::CFG_IDX_W-1:0]               i_cfg_index,
    input  logic [lsmr_pkg::CFG_DAT_W-1:0]               i_cfg_data
);
    import lsmr_pkg::*;

    t_win_cfg   win_cfg;
    t_ctr_arr   centers;
    t_ctr_arr   centers_mod;
    logic       restart;
    logic       busy;
    logic       take;
    logic       r_s0_valid;
    t_sample    r_s0;
    t_dist_arr  acc_tdata;

    lsmr_cfg_regs #(
        .MAX_SCAN_POINTS (MAX_SCAN_POINTS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (win_cfg),
        .o_centers   (centers),
        .o_restart   (restart)
    );

    lsmr_mod_unit u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_len     (win_cfg.scan_len),
        .i_centers (centers),
        .o_rem     (centers_mod),
        .o_busy    (busy)
    );

    // input register
    assign o_s_axis_tready = !busy && (!r_s0_valid || take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_s0_valid <= 1'b1;
        end else if (take) begin
            r_s0_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_s0.range_mm <= i_s_axis_tdata;
            r_s0.ok       <= i_s_axis_tuser;
            r_s0.last     <= i_s_axis_tlast;
        end
    end

    lsmr_sector_acc u_acc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (win_cfg),
        .i_centers       (centers_mod),
        .i_busy          (busy),
        .i_valid         (r_s0_valid),
        .i_sample        (r_s0),
        .o_take          (take),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (acc_tdata)
    );

    assign o_m_axis_tdata = acc_tdata;

endmodule

>>> design/lidar_sector_min_range_props.sv
`include "lidar_sector_min_range_macros.svh"

module lidar_sector_min_range_props (
    input logic                                           i_clk,
    input logic                                           i_rst_n,
    input logic                                           i_s_axis_tvalid,
    input logic                                           o_s_axis_tready,
    input logic [lsmr_pkg::RANGE_W-1:0]                   i_s_axis_tdata,
    input logic                                           i_s_axis_tuser,
    input logic                                           i_s_axis_tlast,
    input logic                                           o_m_axis_tvalid,
    input logic                                           i_m_axis_tready,
    input logic [lsmr_pkg::NUM_SEC*lsmr_pkg::RANGE_W-1:0] o_m_axis_tdata,
    input logic                                           i_cfg_valid,
    input logic                                           o_cfg_ready,
    input logic [lsmr_pkg::CFG_IDX_W-1:0]                 i_cfg_index,
    input logic [lsmr_pkg::CFG_DAT_W-1:0]                 i_cfg_data
);
    import lsmr_pkg::*;

    // a stalled result holds its value
    `LSMR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata))

    // a center or length write starts the remainder pass, input held off
    `LSMR_ASSERT_NEXT(a_cfg_stall, i_clk, i_rst_n,
        i_cfg_valid && o_cfg_ready &&
        (i_cfg_index == CFG_FRONT_CENTER || i_cfg_index == CFG_LEFT_CENTER ||
         i_cfg_index == CFG_RIGHT_CENTER || i_cfg_index == CFG_SCAN_LENGTH),
        !o_s_axis_tready)

    // first cycle out of reset is spent on the remainder pass
    `LSMR_ASSERT_NOW(a_rst_stall, i_clk, i_rst_n,
        !$past(i_rst_n),
        !o_s_axis_tready)

    // a new result is only produced when the input side was open
    `LSMR_ASSERT_NOW(a_out_open, i_clk, i_rst_n,
        $rose(o_m_axis_tvalid),
        $past(o_s_axis_tready))

endmodule

bind lidar_sector_min_range lidar_sector_min_range_props u_props (.*);
